### design/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared command codes and sequencer state type for the interval set tracker.
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_PROC  = 5'b00100,
      S_PROC2 = 5'b01000,
      S_FINAL = 5'b10000
   } state_type;

endpackage

### design/ist_table.sv
// ----------------------------------------------------------------------------
// ist_table
// Two-bank interval memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ist_table #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_start,
   input  logic [DW-1:0] wr_end,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_start,
   output logic [DW-1:0] rd_end
);

   logic [DW-1:0] mem_start [DEPTH];
   logic [DW-1:0] mem_end   [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_end[wr_addr]   <= wr_end;
      end
   end

   always_ff @(posedge clock) begin
      rd_start <= mem_start[rd_addr];
      rd_end   <= mem_end[rd_addr];
   end

endmodule

### design/interval_set_tracker.sv
// ----------------------------------------------------------------------------
// interval_set_tracker
// Sorted table of disjoint half-open intervals with add, remove and query.
// ----------------------------------------------------------------------------
// Pulse start with req_command, req_range_start and req_range_end while busy
// is low; the beat is taken at that edge. Busy stays high until the command
// finishes, then rsp_valid pulses for one cycle with rsp_covered (query
// answer) and rsp_status (1 when the table would overflow and was left as
// it was). Busy is low in the rsp_valid cycle, so a new command may start
// right then.
// A command that does nothing (empty add/remove, unused code) answers in
// the cycle after start. Otherwise the sequencer walks the n stored
// intervals through the single read port of the table memory, with a read
// state and a process state per interval, an extra write state for the one
// interval that writes two entries, and for add a final state that places
// the new range when no stored interval did so.
// The new table is built in the spare bank and made current by flipping the
// bank bit, so a refused command leaves the table untouched.
// Reset empties the table at once; memory contents need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module interval_set_tracker
   import ist_pkg::*;
#(
   parameter int MAX_INTERVALS = 16,
   parameter int COORD_BITS    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [COORD_BITS-1:0] req_range_start,
   input  logic [COORD_BITS-1:0] req_range_end,
   output logic                  rsp_valid,
   output logic                  rsp_covered,
   output logic                  rsp_status
);

   localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int N_W   = $clog2(MAX_INTERVALS + 3);
   localparam int AW    = IDX_W + 1;

   state_type              state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [COORD_BITS-1:0]  s_ff, s_in, e_ff, e_in;
   logic [COORD_BITS-1:0]  ns_ff, ns_in, ne_ff, ne_in;
   logic [COORD_BITS-1:0]  pend_s_ff, pend_s_in, pend_e_ff, pend_e_in;
   logic [COORD_BITS-1:0]  last_end_ff, last_end_in;
   logic                   placed_ff, placed_in, found_ff, found_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in, count_ff, count_in;
   logic [N_W-1:0]         wr_n_ff, wr_n_in;
   logic                   bank_ff, bank_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_covered_ff, rsp_covered_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   wr_en;
   logic [COORD_BITS-1:0]  wr_s, wr_e, rd_s, rd_e;
   logic                   w1_ok, w2_ok;
   logic [COORD_BITS-1:0]  w1_s, w1_e, w2_s, w2_e;
   logic [N_W-1:0]         final_n;
   logic                   fin;

   ist_table #(
      .DEPTH (1 << AW),
      .AW    (AW),
      .DW    (COORD_BITS)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  ({~bank_ff, wr_n_ff[IDX_W-1:0]}),
      .wr_start (wr_s),
      .wr_end   (wr_e),
      .rd_addr  ({bank_ff, rd_idx_ff[IDX_W-1:0]}),
      .rd_start (rd_s),
      .rd_end   (rd_e)
   );

   // entries kept or produced by the interval just read
   always_comb begin
      w1_ok = 1'b0;
      w1_s  = rd_s;
      w1_e  = rd_e;
      w2_ok = 1'b0;
      w2_s  = rd_s;
      w2_e  = rd_e;
      if (cmd_ff == CMD_ADD) begin
         if (rd_e < s_ff) begin
            w1_ok = 1'b1;
         end else if (rd_s > e_ff) begin
            if (!placed_ff) begin
               w1_ok = 1'b1;
               w1_s  = ns_ff;
               w1_e  = ne_ff;
               w2_ok = 1'b1;
            end else begin
               w1_ok = 1'b1;
            end
         end
      end else if (cmd_ff == CMD_REMOVE) begin
         if (rd_e <= s_ff || rd_s >= e_ff) begin
            w1_ok = 1'b1;
         end else begin
            w1_ok = rd_s < s_ff;
            w1_e  = s_ff;
            w2_ok = rd_e > e_ff;
            w2_s  = e_ff;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      s_in           = s_ff;
      e_in           = e_ff;
      ns_in          = ns_ff;
      ne_in          = ne_ff;
      pend_s_in      = pend_s_ff;
      pend_e_in      = pend_e_ff;
      last_end_in    = last_end_ff;
      placed_in      = placed_ff;
      found_in       = found_ff;
      rd_idx_in      = rd_idx_ff;
      count_in       = count_ff;
      wr_n_in        = wr_n_ff;
      bank_in        = bank_ff;
      rsp_valid_in   = 1'b0;
      rsp_covered_in = rsp_covered_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_s           = w1_s;
      wr_e           = w1_e;
      fin            = 1'b0;
      final_n        = wr_n_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_command;
               s_in        = req_range_start;
               e_in        = req_range_end;
               ns_in       = req_range_start;
               ne_in       = req_range_end;
               placed_in   = 1'b0;
               found_in    = 1'b0;
               last_end_in = '0;
               rd_idx_in   = '0;
               wr_n_in     = '0;
               if (req_command == CMD_QUERY ||
                   ((req_command == CMD_ADD || req_command == CMD_REMOVE) &&
                    req_range_start < req_range_end)) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_covered_in = 1'b0;
                  rsp_status_in  = 1'b0;
               end
            end
         end
         S_READ: begin
            if (rd_idx_ff == count_ff) begin
               if (cmd_ff == CMD_ADD) begin
                  state_in = S_FINAL;
               end else begin
                  fin = 1'b1;
               end
            end else begin
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            state_in  = S_READ;
            if (cmd_ff == CMD_QUERY) begin
               if (rd_s <= s_ff) begin
                  found_in    = 1'b1;
                  last_end_in = rd_e;
               end
            end else if (cmd_ff == CMD_ADD && !w1_ok) begin
               // overlapping or touching: grow the merged range
               if (rd_s < ns_ff) ns_in = rd_s;
               if (rd_e > ne_ff) ne_in = rd_e;
            end
            if (w1_ok || w2_ok) begin
               wr_en   = wr_n_ff < N_W'(MAX_INTERVALS);
               wr_s    = w1_ok ? w1_s : w2_s;
               wr_e    = w1_ok ? w1_e : w2_e;
               wr_n_in = wr_n_ff + 1'b1;
            end
            if (w1_ok && w2_ok) begin
               pend_s_in = w2_s;
               pend_e_in = w2_e;
               state_in  = S_PROC2;
            end
            if (cmd_ff == CMD_ADD && w2_ok) placed_in = 1'b1;
         end
         S_PROC2: begin
            wr_en    = wr_n_ff < N_W'(MAX_INTERVALS);
            wr_s     = pend_s_ff;
            wr_e     = pend_e_ff;
            wr_n_in  = wr_n_ff + 1'b1;
            state_in = S_READ;
         end
         S_FINAL: begin
            if (!placed_ff) begin
               wr_en   = wr_n_ff < N_W'(MAX_INTERVALS);
               wr_s    = ns_ff;
               wr_e    = ne_ff;
               final_n = wr_n_ff + 1'b1;
            end
            fin = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         if (cmd_ff == CMD_QUERY) begin
            rsp_covered_in = found_ff && (last_end_ff >= e_ff);
            rsp_status_in  = 1'b0;
         end else begin
            rsp_covered_in = 1'b0;
            if (final_n > N_W'(MAX_INTERVALS)) begin
               rsp_status_in = 1'b1;
            end else begin
               rsp_status_in = 1'b0;
               count_in      = CNT_W'(final_n);
               bank_in       = ~bank_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      s_ff           <= s_in;
      e_ff           <= e_in;
      ns_ff          <= ns_in;
      ne_ff          <= ne_in;
      pend_s_ff      <= pend_s_in;
      pend_e_ff      <= pend_e_in;
      last_end_ff    <= last_end_in;
      placed_ff      <= placed_in;
      found_ff       <= found_in;
      rd_idx_ff      <= rd_idx_in;
      wr_n_ff        <= wr_n_in;
      rsp_covered_ff <= rsp_covered_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_covered = rsp_covered_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

### design/ist_checker.sv
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks of the command and result beats of the tracker.
// ----------------------------------------------------------------------------
module ist_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_covered,
   input logic rsp_status
);

   // a taken command either answers at once or keeps the block busy
   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("command beat neither answered nor in progress");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while still busy");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   a_covered_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_covered) |-> !rsp_status)
      else $error("query answer flagged full");

endmodule

bind interval_set_tracker ist_checker u_ist_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_covered (rsp_covered),
   .rsp_status  (rsp_status)
);
